// ===== rtl/core/svh_pkg.sv =====
`timescale 1ns / 1ps

package svh_pkg;

  localparam int VALUE_W = 32;
  localparam int OP_W    = 3;

  // Null cell marker: most negative 32-bit value.
  localparam logic [VALUE_W-1:0] NULL_VALUE = 32'h8000_0000;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 3'd0,
    OP_LOOKUP = 3'd1,
    OP_REWIND = 3'd2,
    OP_NEXT   = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_WALK   = 8'b0000_0010,
    ST_CNT    = 8'b0000_0100,
    ST_FILL   = 8'b0000_1000,
    ST_LEFT   = 8'b0001_0000,
    ST_NXNODE = 8'b0010_0000,
    ST_NXSCAN = 8'b0100_0000,
    ST_NXCNT  = 8'b1000_0000
  } state_e;

endpackage

// ===== rtl/core/svh_ram.sv =====
`timescale 1ns / 1ps

module svh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/core/sparse_value_histogram_core.sv =====
`timescale 1ns / 1ps
// Steps from accept to result: clear, rewind on an empty store, null add/lookup, unknown ops
// and a next without a valid cursor finish from idle. Add/lookup: a node read per tree node
// visited, then a count update on a hit or a fill of all 2^SLOT_BITS slots of a new block.
// Rewind walks the left spine. Next: cursor node read, a scan and count read per slot, threads.
// One beat in flight, paced by one read port per RAM; done_o strobes one cycle, never stalled.
// Reset is asynchronous (rst_ni low): store empty, cursor cleared, null count zero.

module sparse_value_histogram_core #(
  parameter int MAX_BLOCKS  = 256,
  parameter int SLOT_BITS   = 6,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [svh_pkg::OP_W-1:0]    op_i,
  input  logic [svh_pkg::VALUE_W-1:0] value_i,
  output logic                        done_o,
  output logic [svh_pkg::VALUE_W-1:0] out_value_o,
  output logic [svh_pkg::VALUE_W-1:0] count_o,
  output logic                        found_o,
  output logic                        table_full_o,
  output logic [svh_pkg::VALUE_W-1:0] null_total_o
);

  import svh_pkg::*;

  localparam int NSLOTS = 1 << SLOT_BITS;
  localparam int NODE_W = $clog2(MAX_BLOCKS + 1);
  localparam int NB_W   = $clog2(MAX_BLOCKS);
  localparam int RW     = NODE_W + 1;
  localparam int KEY_W  = VALUE_W - SLOT_BITS;
  localparam int NW     = KEY_W + NODE_W + RW;
  localparam int CA_W   = NB_W + SLOT_BITS;
  localparam int CS_W   = SLOT_BITS + 2;

  function automatic logic [NB_W-1:0] naddr(logic [NODE_W-1:0] n);
    logic [NODE_W-1:0] m;
    m = n - 1'b1;
    return m[NB_W-1:0];
  endfunction

  function automatic logic link_ok(logic [RW-1:0] r, logic [NODE_W-1:0] bt);
    return !r[RW-1] && (r[NODE_W-1:0] != '0) && (r[NODE_W-1:0] <= bt);
  endfunction

  state_e state_q, state_d;
  logic [OP_W-1:0]          op_q, op_d;
  logic signed [KEY_W-1:0]  key_q, key_d;
  logic [SLOT_BITS-1:0]     slot_q, slot_d;
  logic [NODE_W-1:0]        node_q, node_d;
  logic signed [KEY_W-1:0]  pkey_q, pkey_d;
  logic [NODE_W-1:0]        pleft_q, pleft_d;
  logic [RW-1:0]            pright_q, pright_d;
  logic [NODE_W-1:0]        pidx_q, pidx_d;
  logic [NODE_W-1:0]        bt_q, bt_d;
  logic [NODE_W-1:0]        cblk_q, cblk_d;
  logic signed [CS_W-1:0]   cslot_q, cslot_d;
  logic [COUNT_WIDTH-1:0]   null_q, null_d;
  logic [SLOT_BITS-1:0]     fill_q, fill_d;
  logic                     first_q, first_d;
  logic                     nxmode_q, nxmode_d;
  logic [CA_W-1:0]          caddr_q, caddr_d;
  logic                     done_q, done_d;
  logic [VALUE_W-1:0]       outv_q, outv_d;
  logic [VALUE_W-1:0]       cnt_q, cnt_d;
  logic                     found_q, found_d;
  logic                     full_q, full_d;

  // memory ports
  logic              n_we;
  logic [NB_W-1:0]   n_waddr, n_raddr;
  logic [NW-1:0]     n_wdata, n_rdata;
  logic              c_we;
  logic [CA_W-1:0]   c_waddr, c_raddr;
  logic [COUNT_WIDTH-1:0] c_wdata, c_rdata;

  svh_ram #(.WIDTH(NW), .DEPTH(MAX_BLOCKS)) u_node_ram (
    .clk_i  (clk_i),
    .we_i   (n_we),
    .waddr_i(n_waddr),
    .wdata_i(n_wdata),
    .raddr_i(n_raddr),
    .rdata_o(n_rdata)
  );

  svh_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(MAX_BLOCKS * NSLOTS)) u_count_ram (
    .clk_i  (clk_i),
    .we_i   (c_we),
    .waddr_i(c_waddr),
    .wdata_i(c_wdata),
    .raddr_i(c_raddr),
    .rdata_o(c_rdata)
  );

  // value split: negatives map through the one's complement of the magnitude
  logic [VALUE_W-1:0]       mag;
  logic signed [KEY_W-1:0]  in_key;
  logic [SLOT_BITS-1:0]     in_slot;
  logic                     in_null;

  assign mag     = -value_i;
  assign in_key  = value_i[VALUE_W-1] ? ~mag[VALUE_W-1:SLOT_BITS] : value_i[VALUE_W-1:SLOT_BITS];
  assign in_slot = value_i[VALUE_W-1] ? ~mag[SLOT_BITS-1:0] : value_i[SLOT_BITS-1:0];
  assign in_null = (value_i == NULL_VALUE);

  logic signed [KEY_W-1:0] rk;
  logic [NODE_W-1:0]       rl;
  logic [RW-1:0]           rr;

  assign rk = n_rdata[NW-1 -: KEY_W];
  assign rl = n_rdata[RW+NODE_W-1 -: NODE_W];
  assign rr = n_rdata[RW-1:0];

  logic [63:0] cext, nullext;
  assign cext    = 64'(c_rdata);
  assign nullext = 64'(null_q);

  always_comb begin
    logic                   fin;
    logic [VALUE_W-1:0]     r_val, r_cnt;
    logic                   r_found, r_full;
    logic [RW-1:0]          nxt, rabs;
    logic signed [CS_W-1:0] s;
    logic [RW-1:0]          negp;

    state_d  = state_q;
    op_d     = op_q;
    key_d    = key_q;
    slot_d   = slot_q;
    node_d   = node_q;
    pkey_d   = pkey_q;
    pleft_d  = pleft_q;
    pright_d = pright_q;
    pidx_d   = pidx_q;
    bt_d     = bt_q;
    cblk_d   = cblk_q;
    cslot_d  = cslot_q;
    null_d   = null_q;
    fill_d   = fill_q;
    first_d  = first_q;
    nxmode_d = nxmode_q;
    caddr_d  = caddr_q;
    done_d   = 1'b0;
    outv_d   = outv_q;
    cnt_d    = cnt_q;
    found_d  = found_q;
    full_d   = full_q;

    n_we    = 1'b0;
    n_waddr = '0;
    n_wdata = '0;
    n_raddr = '0;
    c_we    = 1'b0;
    c_waddr = '0;
    c_wdata = '0;
    c_raddr = caddr_q;

    fin     = 1'b0;
    r_val   = '0;
    r_cnt   = '0;
    r_found = 1'b0;
    r_full  = 1'b0;
    nxt     = '0;
    rabs    = '0;
    s       = cslot_q + 1'b1;
    negp    = -{1'b0, pidx_q};

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          op_d   = op_i;
          key_d  = in_key;
          slot_d = in_slot;
          node_d = NODE_W'(1);
          unique case (op_i)
            OP_ADD: begin
              if (in_null) begin
                if (null_q != '1) begin
                  null_d = null_q + 1'b1;
                end
                fin = 1'b1;
              end else if (bt_q == '0) begin
                bt_d    = NODE_W'(1);
                first_d = 1'b1;
                fill_d  = '0;
                state_d = ST_FILL;
              end else begin
                state_d = ST_WALK;
              end
            end
            OP_LOOKUP: begin
              if (in_null) begin
                r_cnt   = nullext[VALUE_W-1:0];
                r_found = (null_q != '0);
                fin     = 1'b1;
              end else if (bt_q != '0) begin
                state_d = ST_WALK;
              end else begin
                fin = 1'b1;
              end
            end
            OP_REWIND: begin
              if (bt_q != '0) begin
                nxmode_d = 1'b0;
                state_d  = ST_LEFT;
              end else begin
                fin = 1'b1;
              end
            end
            OP_NEXT: begin
              if (link_ok({1'b0, cblk_q}, bt_q)) begin
                n_raddr = naddr(cblk_q);
                state_d = ST_NXNODE;
              end else begin
                fin = 1'b1;
              end
            end
            OP_CLEAR: begin
              bt_d    = '0;
              cblk_d  = '0;
              cslot_d = '1;
              fin     = 1'b1;
            end
            default: fin = 1'b1;
          endcase
        end
      end

      ST_WALK: begin
        pkey_d   = rk;
        pleft_d  = rl;
        pright_d = rr;
        pidx_d   = node_q;
        nxt      = (rk > key_q) ? {1'b0, rl} : rr;
        if (rk == key_q) begin
          caddr_d = {naddr(node_q), slot_q};
          c_raddr = caddr_d;
          state_d = ST_CNT;
        end else if (link_ok(nxt, bt_q)) begin
          node_d  = nxt[NODE_W-1:0];
          n_raddr = naddr(node_d);
        end else if (op_q != OP_ADD) begin
          fin = 1'b1;
        end else if (bt_q >= NODE_W'(MAX_BLOCKS)) begin
          r_full = 1'b1;
          fin    = 1'b1;
        end else begin
          bt_d    = bt_q + 1'b1;
          first_d = 1'b0;
          fill_d  = '0;
          state_d = ST_FILL;
        end
      end

      ST_CNT: begin
        if (op_q == OP_ADD) begin
          c_we    = 1'b1;
          c_waddr = caddr_q;
          c_wdata = (c_rdata == '1) ? c_rdata : c_rdata + 1'b1;
        end else begin
          r_cnt   = cext[VALUE_W-1:0];
          r_found = (c_rdata != '0);
        end
        fin = 1'b1;
      end

      ST_FILL: begin
        // Zero the new block's slots, seeding the added one; link in while slots 0 and 1 are written.
        c_we    = 1'b1;
        c_waddr = {naddr(bt_q), fill_q};
        c_wdata = (fill_q == slot_q) ? COUNT_WIDTH'(1) : '0;
        if (fill_q == '0) begin
          n_we    = 1'b1;
          n_waddr = naddr(bt_q);
          n_wdata = {key_q, NODE_W'(0),
                     first_q ? RW'(0) : ((pkey_q > key_q) ? negp : pright_q)};
        end else if (fill_q == SLOT_BITS'(1) && !first_q) begin
          n_we    = 1'b1;
          n_waddr = naddr(pidx_q);
          if (pkey_q > key_q) begin
            n_wdata = {pkey_q, bt_q, pright_q};
          end else begin
            n_wdata = {pkey_q, pleft_q, {1'b0, bt_q}};
          end
        end
        fill_d = fill_q + 1'b1;
        if (fill_q == '1) begin
          fin = 1'b1;
        end
      end

      ST_LEFT: begin
        if (link_ok({1'b0, rl}, bt_q)) begin
          node_d  = rl;
          n_raddr = naddr(rl);
        end else begin
          cblk_d  = node_q;
          cslot_d = '1;
          if (nxmode_q) begin
            pkey_d   = rk;
            pright_d = rr;
            state_d  = ST_NXSCAN;
          end else begin
            fin = 1'b1;
          end
        end
      end

      ST_NXNODE: begin
        pkey_d   = rk;
        pright_d = rr;
        state_d  = ST_NXSCAN;
      end

      ST_NXSCAN: begin
        if (s == CS_W'(NSLOTS)) begin
          rabs = pright_q[RW-1] ? -pright_q : pright_q;
          if (rabs == '0 || rabs > {1'b0, bt_q}) begin
            cblk_d  = '0;
            cslot_d = s;
            fin     = 1'b1;
          end else if (pright_q[RW-1]) begin
            // thread: jump straight to the in-order successor
            cblk_d  = rabs[NODE_W-1:0];
            cslot_d = '1;
            n_raddr = naddr(rabs[NODE_W-1:0]);
            state_d = ST_NXNODE;
          end else begin
            node_d   = rabs[NODE_W-1:0];
            n_raddr  = naddr(rabs[NODE_W-1:0]);
            nxmode_d = 1'b1;
            state_d  = ST_LEFT;
          end
        end else begin
          cslot_d = s;
          caddr_d = {naddr(cblk_q), s[SLOT_BITS-1:0]};
          c_raddr = caddr_d;
          state_d = ST_NXCNT;
        end
      end

      ST_NXCNT: begin
        if (c_rdata != '0) begin
          r_val   = VALUE_W'({pkey_q, cslot_q[SLOT_BITS-1:0]})
                    + VALUE_W'(pkey_q[KEY_W-1]);
          r_cnt   = cext[VALUE_W-1:0];
          r_found = 1'b1;
          fin     = 1'b1;
        end else begin
          state_d = ST_NXSCAN;
        end
      end

      default: state_d = ST_IDLE;
    endcase

    // root read shares the idle arm's address when a walk starts
    if (state_q == ST_IDLE && start_i && state_d != ST_NXNODE) begin
      n_raddr = naddr(NODE_W'(1));
    end

    if (fin) begin
      done_d  = 1'b1;
      state_d = ST_IDLE;
      outv_d  = r_val;
      cnt_d   = r_cnt;
      found_d = r_found;
      full_d  = r_full;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      op_q     <= '0;
      key_q    <= '0;
      slot_q   <= '0;
      node_q   <= '0;
      pkey_q   <= '0;
      pleft_q  <= '0;
      pright_q <= '0;
      pidx_q   <= '0;
      bt_q     <= '0;
      cblk_q   <= '0;
      cslot_q  <= '1;
      null_q   <= '0;
      fill_q   <= '0;
      first_q  <= 1'b0;
      nxmode_q <= 1'b0;
      caddr_q  <= '0;
      done_q   <= 1'b0;
      outv_q   <= '0;
      cnt_q    <= '0;
      found_q  <= 1'b0;
      full_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      op_q     <= op_d;
      key_q    <= key_d;
      slot_q   <= slot_d;
      node_q   <= node_d;
      pkey_q   <= pkey_d;
      pleft_q  <= pleft_d;
      pright_q <= pright_d;
      pidx_q   <= pidx_d;
      bt_q     <= bt_d;
      cblk_q   <= cblk_d;
      cslot_q  <= cslot_d;
      null_q   <= null_d;
      fill_q   <= fill_d;
      first_q  <= first_d;
      nxmode_q <= nxmode_d;
      caddr_q  <= caddr_d;
      done_q   <= done_d;
      outv_q   <= outv_d;
      cnt_q    <= cnt_d;
      found_q  <= found_d;
      full_q   <= full_d;
    end
  end

  assign busy_o       = (state_q != ST_IDLE);
  assign done_o       = done_q;
  assign out_value_o  = outv_q;
  assign count_o      = cnt_q;
  assign found_o      = found_q;
  assign table_full_o = full_q;
  assign null_total_o = nullext[VALUE_W-1:0];

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register not one-hot");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while busy");

  a_clear_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && op_i == OP_CLEAR) |=> (done_o && bt_q == '0))
    else $error("clear did not finish in one cycle");

  a_bt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bt_q <= NODE_W'(MAX_BLOCKS))
    else $error("block count beyond store size");

  a_full_no_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && table_full_o) |-> $stable(bt_q))
    else $error("dropped add changed block count");

endmodule

// ===== bench/sparse_value_histogram_checker.sv =====
`timescale 1ns / 1ps

module sparse_value_histogram_checker #(
  parameter int MAX_BLOCKS = 256,
  parameter int SLOT_BITS  = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [2:0]  op_i,
  input  logic [31:0] value_i,
  input  logic        done_i,
  input  logic [31:0] out_value_i,
  input  logic [31:0] count_i,
  input  logic        found_i,
  input  logic        table_full_i,
  input  logic [31:0] null_total_i,
  output int          errors_o,
  output int          pending_o,
  output int          hits_o,
  output int          full_drops_o
);
  import svh_pkg::*;

  localparam int NSLOTS = 1 << SLOT_BITS;
  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [31:0] out_value;
    logic [31:0] count;
    logic        found;
    logic        table_full;
    logic [31:0] null_total;
  } answer_t;

  answer_t answers_q[$];

  longint      node_key [MAX_BLOCKS+1];
  int          node_left [MAX_BLOCKS+1];
  int          node_right[MAX_BLOCKS+1];
  logic [31:0] bin_count[(MAX_BLOCKS+1)*NSLOTS];
  int          n_blocks;
  int          cur_node;
  int          cur_slot;
  logic [31:0] null_cnt;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("[%0t] mismatch %s: got %h want %h", $realtime, what, got, want);
    errors_o++;
  endtask

  function automatic bit live(int n);
    return n >= 1 && n <= n_blocks;
  endfunction

  function automatic int leftmost_of(int n);
    int m;
    m = n;
    while (live(node_left[m])) m = node_left[m];
    return m;
  endfunction

  task automatic split(input longint v, output longint k, output int s);
    longint t;
    if (v < 0) begin
      k = -((-v) >>> SLOT_BITS) - 1;
      t = v + ((-k) <<< SLOT_BITS) - 1;
    end else begin
      k = v >>> SLOT_BITS;
      t = v - (k <<< SLOT_BITS);
    end
    s = int'(t) & (NSLOTS - 1);
  endtask

  // Walk the tree; return node or 0, last node visited in par.
  task automatic search(input longint k, output int hit, output int par);
    int q;
    q = 1;
    par = 1;
    hit = 0;
    while (live(q)) begin
      par = q;
      if (node_key[q] == k) begin
        hit = q;
        return;
      end
      q = (node_key[q] > k) ? node_left[q] : node_right[q];
    end
  endtask

  task automatic open_block(input int n, input longint k, input int s);
    for (int i = 0; i < NSLOTS; i++) bin_count[n*NSLOTS+i] = '0;
    node_key[n] = k;
    node_left[n] = 0;
    bin_count[n*NSLOTS+s] = 1;
  endtask

  task automatic predict(input logic [2:0] op, input logic [31:0] raw, output answer_t a);
    longint v, k, kk;
    int s, hit, par, n, r;
    bit is_null;
    v = longint'($signed(raw));
    is_null = (raw == NULL_VALUE);
    a = '0;
    case (op)
      OP_ADD: begin
        if (is_null) begin
          if (null_cnt != CNT_MAX) null_cnt++;
        end else begin
          split(v, k, s);
          if (n_blocks == 0) begin
            n_blocks = 1;
            open_block(1, k, s);
            node_right[1] = 0;
          end else begin
            search(k, hit, par);
            if (hit != 0) begin
              if (bin_count[hit*NSLOTS+s] != CNT_MAX) bin_count[hit*NSLOTS+s]++;
            end else if (n_blocks >= MAX_BLOCKS) begin
              a.table_full = 1'b1;
            end else begin
              n_blocks++;
              n = n_blocks;
              open_block(n, k, s);
              if (node_key[par] > k) begin
                node_right[n] = -par;
                node_left[par] = n;
              end else begin
                node_right[n] = node_right[par];
                node_right[par] = n;
              end
            end
          end
        end
      end
      OP_LOOKUP: begin
        if (is_null) begin
          a.count = null_cnt;
          a.found = null_cnt != 0;
        end else if (n_blocks > 0) begin
          split(v, k, s);
          search(k, hit, par);
          if (hit != 0) begin
            a.count = bin_count[hit*NSLOTS+s];
            a.found = a.count != 0;
          end
        end
      end
      OP_REWIND: begin
        if (n_blocks > 0) begin
          cur_node = leftmost_of(1);
          cur_slot = -1;
        end
      end
      OP_NEXT: begin
        if (n_blocks > 0 && live(cur_node)) begin
          forever begin
            cur_slot++;
            if (cur_slot >= NSLOTS) begin
              r = node_right[cur_node];
              if (r == 0 || r < -n_blocks || r > n_blocks) begin
                cur_node = 0;
                break;
              end
              cur_node = (r < 0) ? -r : leftmost_of(r);
              cur_slot = -1;
              continue;
            end
            if (bin_count[cur_node*NSLOTS+cur_slot] != 0) begin
              a.count = bin_count[cur_node*NSLOTS+cur_slot];
              kk = node_key[cur_node];
              if (kk < 0) a.out_value = 32'(-((-kk) <<< SLOT_BITS) + cur_slot + 1);
              else        a.out_value = 32'((kk <<< SLOT_BITS) + cur_slot);
              a.found = 1'b1;
              break;
            end
          end
        end
      end
      OP_CLEAR: begin
        n_blocks = 0;
        cur_node = 0;
        cur_slot = -1;
      end
      default: ;
    endcase
    a.null_total = null_cnt;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t want, made;
    if (!rst_ni) begin
      n_blocks = 0;
      cur_node = 0;
      cur_slot = -1;
      null_cnt = '0;
      errors_o = 0;
      hits_o = 0;
      full_drops_o = 0;
      answers_q.delete();
      pending_o = 0;
    end else begin
      // retire the finished beat before queueing a new one
      if (done_i) begin
        if (answers_q.size() == 0) begin
          $display("[%0t] result beat with nothing outstanding", $realtime);
          errors_o++;
        end else begin
          want = answers_q.pop_front();
          if (out_value_i !== want.out_value) report("out_value", out_value_i, want.out_value);
          if (count_i !== want.count) report("count", count_i, want.count);
          if (found_i !== want.found) report("found", found_i, want.found);
          if (table_full_i !== want.table_full)
            report("table_full", table_full_i, want.table_full);
          if (null_total_i !== want.null_total)
            report("null_total", null_total_i, want.null_total);
          if (want.found) hits_o++;
          if (want.table_full) full_drops_o++;
        end
      end
      if (start_i && !busy_i) begin
        predict(op_i, value_i, made);
        answers_q.push_back(made);
      end
      pending_o = answers_q.size();
    end
  end

endmodule

// ===== bench/sparse_value_histogram_core_tb.sv =====
`timescale 1ns / 1ps

module sparse_value_histogram_core_tb;
  import svh_pkg::*;

  localparam int LIMIT = 3_000_000;
  localparam logic [2:0] OP_SPARE = 3'(OP_CLEAR) + 3'd1;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic [2:0]  op_i = '0;
  logic [31:0] value_i = '0;
  logic        busy_o, done_o, found_o, table_full_o;
  logic [31:0] out_value_o, count_o, null_total_o;
  int          errors, pending, hits, full_drops;
  int          cycles = 0;
  int          sent = 0;
  logic [31:0] seen_values[$];

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  sparse_value_histogram_core dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .op_i, .value_i, .done_o,
    .out_value_o, .count_o, .found_o, .table_full_o, .null_total_o
  );

  sparse_value_histogram_checker chk (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .op_i, .value_i, .done_i(done_o),
    .out_value_i(out_value_o), .count_i(count_o), .found_i(found_o),
    .table_full_i(table_full_o), .null_total_i(null_total_o),
    .errors_o(errors), .pending_o(pending), .hits_o(hits), .full_drops_o(full_drops)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycles, pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic issue(input logic [2:0] op, input logic [31:0] v);
    bit taken;
    start_i <= 1'b1;
    op_i    <= op;
    value_i <= v;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = !busy_o;
    end
    @(negedge clk_i);
    sent++;
    if (op == OP_ADD) seen_values.push_back(v);
  endtask

  task automatic pause();
    int r, g;
    r = $urandom_range(0, 99);
    if (r < 65) g = 0;
    else if (r < 95) g = $urandom_range(1, 3);
    else g = $urandom_range(15, 60);
    if (g > 0) begin
      start_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
  endtask

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35 && seen_values.size() > 0)
      return seen_values[$urandom_range(0, seen_values.size() - 1)];
    if (r < 70) return 32'($signed($urandom_range(0, 1200)) - 600);
    if (r < 78) return NULL_VALUE;
    return $urandom();
  endfunction

  function automatic logic [2:0] pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return OP_ADD;
    if (r < 68) return OP_LOOKUP;
    if (r < 74) return OP_REWIND;
    if (r < 95) return OP_NEXT;
    if (r < 97) return OP_CLEAR;
    return OP_SPARE + 3'($urandom_range(0, 2));
  endfunction

  initial begin
    logic [31:0] dir_vals[6];
    dir_vals = '{32'h7FFF_FFFF, 32'h8000_0001, 32'h0, 32'hFFFF_FFFF, 32'd63, 32'hFFFF_FFC0};
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty store answers, then directed adds, lookups, readout, spare ops and clear
    issue(OP_LOOKUP, 32'd5);
    issue(OP_REWIND, '0);
    issue(OP_NEXT, '0);
    issue(OP_LOOKUP, NULL_VALUE);
    foreach (dir_vals[i]) issue(OP_ADD, dir_vals[i]);
    issue(OP_ADD, NULL_VALUE);
    issue(OP_ADD, 32'h0);
    issue(OP_LOOKUP, NULL_VALUE);
    issue(OP_LOOKUP, 32'h8000_0001);
    issue(OP_LOOKUP, 32'h0);
    issue(OP_NEXT, '0);
    issue(OP_REWIND, '0);
    repeat (8) issue(OP_NEXT, '0);
    issue(OP_SPARE, 32'hFFFF_FFFF);
    issue(3'(OP_SPARE) + 3'd2, 32'h1234_5678);
    issue(OP_CLEAR, '0);
    issue(OP_NEXT, '0);

    // fill the node store past capacity, then sweep it; each add carries a distinct block key
    issue(OP_CLEAR, '0);
    for (int i = 0; i < 270; i++) begin
      issue(OP_ADD, {8'($urandom_range(0, 255)), 18'(i), 6'($urandom_range(0, 63))});
      pause();
    end
    issue(OP_REWIND, '0);
    for (int i = 0; i < 120; i++) begin
      issue(OP_NEXT, '0);
      pause();
    end

    issue(OP_CLEAR, '0);
    seen_values.delete();
    for (int i = 0; i < 1100; i++) begin
      issue(pick_op(), pick_value());
      if (i % 200 < 150) pause();
    end

    start_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    $display("%0d commands over %0d cycles: store-full fill, sorted readout, random mix",
             sent, cycles);
    $display("%0d beats reported a hit, %0d adds dropped on a full store", hits, full_drops);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sparse_value_histogram_core.f =====
rtl/core/svh_pkg.sv
rtl/core/svh_ram.sv
rtl/core/sparse_value_histogram_core.sv
bench/sparse_value_histogram_checker.sv
bench/sparse_value_histogram_core_tb.sv
